>>> hdl/fif_pkg.sv
// free interval finder package: beat types, sequencer states and time constants
// no dependencies
package fif_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned IdxW  = 6;
	localparam logic [TimeW-1:0] TimeInf = '1;

	typedef enum logic {
		ACT_ADD    = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	typedef struct packed {
		logic             action;
		logic [TimeW-1:0] res_start;
		logic [TimeW-1:0] res_end;
	} item_t;

	typedef struct packed {
		logic [TimeW-1:0] gap_start;
		logic [TimeW-1:0] gap_end;
		logic [IdxW-1:0]  gap_index;
		logic             gap_valid;
		logic             overflow;
		logic             last;
	} rslt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_FINAL
	} state_t;

endpackage

>>> hdl/fif_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module fif_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                       wdata,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                       rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/free_interval_finder_core.sv
// free interval finder top level: reservation store, selection sort sweep, result register
// depends on fif_pkg and fif_ram
// add beats are accepted back to back while the sequencer is idle; they give no result
// a finish beat runs n passes for n stored reservations: each of the n
// sorted positions is found by a full pass over the store through its single read port
// results leave through one output register; a stalled result holds the sweep
// reset (arst_n low) empties the store count and clears the overflow flag; store data has no reset
module free_interval_finder_core #(
	parameter int unsigned MAX_RESERVATIONS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  fif_pkg::item_t item,
	output logic          rslt_valid,
	input  logic          rslt_stall,
	output fif_pkg::rslt_t rslt
);
	import fif_pkg::*;

	localparam int unsigned AW = (MAX_RESERVATIONS > 1) ? $clog2(MAX_RESERVATIONS) : 1;
	localparam int unsigned CW = $clog2(MAX_RESERVATIONS + 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_RESERVATIONS);

	state_t state_q, state_d;

	// store bookkeeping
	logic [CW-1:0] cnt_q;
	logic          dropped_q;

	// scan: read address counter and the registered read stage
	logic [CW-1:0]      ra_q;
	logic               rd_vld_s1;
	logic [CW-1:0]      ra_s1;
	logic [2*TimeW-1:0] rdata;
	logic [TimeW-1:0]   rd_start, rd_end;

	// selection: best candidate of this pass, key of previous pick
	logic               found_q;
	logic [TimeW-1:0]   bs_q, be_q;
	logic [CW-1:0]      bi_q;
	logic [TimeW-1:0]   ps_q;
	logic [CW-1:0]      pi_q;
	logic [CW-1:0]      pass_q;

	// sweep
	logic [TimeW-1:0]   cov_q;
	logic               pend_q;
	logic [TimeW-1:0]   pend_gs_q, pend_ge_q;
	logic [CW-1:0]      pend_idx_q;

	logic item_acc, add_acc, fin_acc, wr_en;
	logic can_emit, is_gap, eval_go, final_go, qualify, better, scan_done;
	logic push;
	rslt_t push_data;

	assign item_acc = item_valid && !item_stall;
	assign add_acc  = item_acc && (item.action == ACT_ADD);
	assign fin_acc  = item_acc && (item.action == ACT_FINISH);
	assign wr_en    = add_acc && (cnt_q < MaxCnt);
	assign can_emit = !rslt_valid || !rslt_stall;

	fif_ram #(.Width(2 * TimeW), .Depth(MAX_RESERVATIONS)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({item.res_start, item.res_end}),
		.raddr (ra_q[AW-1:0]),
		.rdata (rdata)
	);
	assign rd_start = rdata[2*TimeW-1:TimeW];
	assign rd_end   = rdata[TimeW-1:0];

	// stable order: key is (start, arrival index)
	assign qualify   = (pass_q == '0) || (rd_start > ps_q) ||
	                   ((rd_start == ps_q) && (ra_s1 > pi_q));
	assign better    = !found_q || (rd_start < bs_q);
	assign scan_done = rd_vld_s1 && (ra_s1 == cnt_q - CW'(1));

	assign is_gap   = bs_q > cov_q;
	assign eval_go  = !is_gap || !pend_q || can_emit;
	assign final_go = can_emit && !(pend_q && (cov_q != TimeInf));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (fin_acc) begin
					state_d = (cnt_q == '0) ? ST_FINAL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (eval_go) begin
					state_d = (pass_q == cnt_q - CW'(1)) ? ST_FINAL : ST_SCAN;
				end
			end
			ST_FINAL: begin
				if (final_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: stall and the beat pushed into the result register
	always_comb begin
		item_stall = 1'b1;
		push       = 1'b0;
		push_data  = '{gap_start: pend_gs_q, gap_end: pend_ge_q,
		               gap_index: IdxW'(pend_idx_q), gap_valid: 1'b1,
		               overflow: dropped_q, last: 1'b0};
		case (state_q)
			ST_IDLE: item_stall = 1'b0;
			ST_SCAN: ;
			ST_EVAL: begin
				// a new gap pushes the one held back
				push = is_gap && pend_q && can_emit;
			end
			ST_FINAL: begin
				push = can_emit;
				if (pend_q) begin
					push_data.last = (cov_q == TimeInf);
				end else if (cov_q != TimeInf) begin
					push_data.gap_start = cov_q;
					push_data.gap_end   = TimeInf;
					push_data.gap_index = IdxW'(cnt_q);
					push_data.last      = 1'b1;
				end else begin
					// no gap at all
					push_data.gap_start = '0;
					push_data.gap_end   = '0;
					push_data.gap_index = '0;
					push_data.gap_valid = 1'b0;
					push_data.last      = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			dropped_q  <= 1'b0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			rslt_valid <= 1'b0;
			ra_q       <= '0;
			pass_q     <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (add_acc) begin
				dropped_q <= 1'b1;
			end
			rd_vld_s1 <= (state_q == ST_SCAN) && (ra_q < cnt_q) && !scan_done;
			if (fin_acc) begin
				pass_q  <= '0;
				ra_q    <= '0;
				found_q <= 1'b0;
				pend_q  <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (scan_done) begin
					ra_q <= '0;
				end else if (ra_q < cnt_q) begin
					ra_q <= ra_q + CW'(1);
				end
				if (rd_vld_s1 && qualify && better) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_EVAL && eval_go) begin
				pass_q  <= pass_q + CW'(1);
				found_q <= 1'b0;
				if (is_gap) begin
					pend_q <= 1'b1;
				end
			end
			if (state_q == ST_FINAL && push) begin
				pend_q <= 1'b0;
			end
			if (state_q == ST_FINAL && final_go) begin
				cnt_q     <= '0;
				dropped_q <= 1'b0;
			end
			if (push) begin
				rslt_valid <= 1'b1;
			end else if (!rslt_stall) begin
				rslt_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ra_s1 <= ra_q;
		if (fin_acc) begin
			cov_q <= '0;
		end
		if (state_q == ST_SCAN && rd_vld_s1 && qualify && better) begin
			bs_q <= rd_start;
			be_q <= rd_end;
			bi_q <= ra_s1;
		end
		if (state_q == ST_EVAL && eval_go) begin
			ps_q <= bs_q;
			pi_q <= bi_q;
			if (be_q > cov_q) begin
				cov_q <= be_q;
			end
			if (is_gap) begin
				pend_gs_q  <= cov_q;
				pend_ge_q  <= bs_q;
				pend_idx_q <= pass_q;
			end
		end
		if (push) begin
			rslt <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.last |=> state_q == ST_IDLE)
		else $error("last result pushed but sequencer not idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MaxCnt)
		else $error("store count beyond capacity");
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == ST_SCAN)
		else $error("store read data outside a scan");
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_q)
		else $error("held gap left over after a run");
`endif
endmodule
